// ----- sv/swm_pkg.sv -----
// Shared types and constants for the sliding-window maximum filter.
package swm_pkg;

    // Sample and configuration widths.
    localparam int SAMPLE_W = 32;
    localparam int WIN_W    = 7;

    // Default deque depth and the window size after reset.
    localparam int WINDOW_MAX_DEF = 64;
    localparam logic [WIN_W-1:0] WIN_RESET = 7'd3;

    // Input queue between the front and the deque engine.
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;
    localparam int Q_CW    = 2;

    // One input item as it travels through the queue.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_sample;
    } t_item;

endpackage

// ----- sv/swm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module swm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/swm_front.sv -----
// Input side: accepts samples and holds them in a short queue for the deque engine.
module swm_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_last_sample,
    output logic                                o_item_valid,
    output swm_pkg::t_item                      o_item,
    input  logic                                i_item_take
);

    swm_pkg::t_item                r_q [swm_pkg::Q_DEPTH];
    logic [swm_pkg::Q_AW-1:0]      r_wp;
    logic [swm_pkg::Q_AW-1:0]      r_rp;
    logic [swm_pkg::Q_CW-1:0]      r_cnt;
    logic [swm_pkg::Q_CW-1:0]      n_cnt;
    logic                          push;
    logic                          pop;

    // The queue stalls the upstream side only when every slot is taken.
    assign o_stall      = (r_cnt == swm_pkg::Q_CW'(swm_pkg::Q_DEPTH));
    assign push         = i_valid && !o_stall;
    assign pop          = i_item_take;
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_q[r_rp];

    // Occupancy follows pushes and pops.
    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + swm_pkg::Q_CW'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - swm_pkg::Q_CW'(1);
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + swm_pkg::Q_AW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + swm_pkg::Q_AW'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{sample: i_sample, last_sample: i_last_sample};
        end
    end

endmodule

// ----- sv/swm_back.sv -----
// Deque engine: keeps the monotonic candidate ring and produces window maxima.
module swm_back #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [swm_pkg::WIN_W-1:0]           i_window,
    input  logic                                i_item_valid,
    input  swm_pkg::t_item                      i_item,
    output logic                                o_item_take,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [swm_pkg::SAMPLE_W-1:0] o_window_max,
    output logic                                o_last_window
);

    // Ring index, count/position and entry widths.
    localparam int AW    = $clog2(WINDOW_MAX);
    localparam int PW    = $clog2(WINDOW_MAX + 1);
    localparam int SW    = AW + 1;
    localparam int EW    = (PW > swm_pkg::WIN_W) ? PW : swm_pkg::WIN_W;
    localparam int ENT_W = swm_pkg::SAMPLE_W + PW;

    logic [AW-1:0]   r_head;
    logic [AW-1:0]   n_head;
    logic [PW-1:0]   r_count;
    logic [PW-1:0]   n_count;
    logic [PW-1:0]   r_pos;
    logic [PW-1:0]   n_pos;
    logic [PW-1:0]   r_filled;
    logic [PW-1:0]   n_filled;
    logic [PW-1:0]   filled_inc;

    logic            r_out_valid;
    logic signed [swm_pkg::SAMPLE_W-1:0] r_out_max;
    logic            r_out_last;

    logic            r_hbyp;
    logic            r_tbyp;
    logic [ENT_W-1:0] r_wq;

    logic [EW-1:0]   win_ext;
    logic [PW-1:0]   w_eff;

    logic [ENT_W-1:0] head_q;
    logic [ENT_W-1:0] tail_q;
    logic [ENT_W-1:0] head_ent;
    logic [ENT_W-1:0] tail_ent;
    logic signed [swm_pkg::SAMPLE_W-1:0] head_val;
    logic signed [swm_pkg::SAMPLE_W-1:0] tail_val;
    logic [PW-1:0]   head_pos;
    logic [PW-1:0]   age;
    logic signed [swm_pkg::SAMPLE_W-1:0] x;

    logic            front_pop;
    logic            back_pop;
    logic            out_free;
    logic            take;
    logic            produce;
    logic signed [swm_pkg::SAMPLE_W-1:0] res_val;

    logic            we;
    logic [AW-1:0]   waddr;
    logic [ENT_W-1:0] wdata;
    logic [SW-1:0]   wsum;
    logic [AW-1:0]   head_raddr;
    logic [AW-1:0]   tail_raddr;
    logic [SW-1:0]   tsum;

    // Effective window: zero counts as one, large values saturate at the depth.
    assign win_ext = EW'(i_window);
    always_comb begin
        if (win_ext == '0) begin
            w_eff = PW'(1);
        end else if (win_ext > EW'(WINDOW_MAX)) begin
            w_eff = PW'(WINDOW_MAX);
        end else begin
            w_eff = PW'(win_ext);
        end
    end

    // Head and tail entries, with a bypass for a write landing on the read slot.
    assign head_ent = r_hbyp ? r_wq : head_q;
    assign tail_ent = r_tbyp ? r_wq : tail_q;
    assign head_val = head_ent[swm_pkg::SAMPLE_W-1:0];
    assign head_pos = head_ent[ENT_W-1:swm_pkg::SAMPLE_W];
    assign tail_val = tail_ent[swm_pkg::SAMPLE_W-1:0];
    assign x        = i_item.sample;

    // The oldest candidate leaves once its age reaches the window; the newest
    // leaves when it is no larger than the incoming sample.
    assign age       = r_pos - head_pos;
    assign front_pop = (r_count != '0) && (age >= w_eff);
    assign back_pop  = (r_count != '0) && (tail_val <= x);
    assign out_free  = !r_out_valid || !i_stall;

    // Slot after the current tail, wrapped around the ring.
    assign wsum  = SW'(r_head) + SW'(r_count);
    assign waddr = (wsum >= SW'(WINDOW_MAX)) ? AW'(wsum - SW'(WINDOW_MAX)) : AW'(wsum);
    assign wdata = {r_pos, x};

    // One step per cycle: front pop, else back pop, else push/report if free.
    always_comb begin
        n_head     = r_head;
        n_count    = r_count;
        n_pos      = r_pos;
        n_filled   = r_filled;
        filled_inc = r_filled;
        take       = 1'b0;
        we         = 1'b0;
        produce    = 1'b0;
        res_val    = (r_count == '0) ? x : head_val;
        if (i_item_valid) begin
            priority if (front_pop) begin
                n_head  = (r_head == AW'(WINDOW_MAX - 1)) ? '0 : r_head + AW'(1);
                n_count = r_count - PW'(1);
            end else if (back_pop) begin
                n_count = r_count - PW'(1);
            end else if (out_free) begin
                take = 1'b1;
                if (r_count != PW'(WINDOW_MAX)) begin
                    we      = 1'b1;
                    n_count = r_count + PW'(1);
                end
                n_pos = r_pos + PW'(1);
                if (r_filled != PW'(WINDOW_MAX)) begin
                    filled_inc = r_filled + PW'(1);
                end
                n_filled = filled_inc;
                produce  = (filled_inc >= w_eff);
                if (i_item.last_sample) begin
                    n_head   = '0;
                    n_count  = '0;
                    n_pos    = '0;
                    n_filled = '0;
                end
            end else begin
                // The result register is still held: the sample waits.
                take = 1'b0;
            end
        end
    end

    // Read addresses follow next cycle's head and tail.
    assign head_raddr = n_head;
    assign tsum       = SW'(n_head) + SW'(n_count) - SW'(1);
    always_comb begin
        if (n_count == '0) begin
            tail_raddr = n_head;
        end else if (tsum >= SW'(WINDOW_MAX)) begin
            tail_raddr = AW'(tsum - SW'(WINDOW_MAX));
        end else begin
            tail_raddr = AW'(tsum);
        end
    end

    // Two copies of the ring, one read at the head and one at the tail.
    swm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (WINDOW_MAX)
    ) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (head_raddr),
        .o_rdata (head_q)
    );

    swm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (WINDOW_MAX)
    ) u_tail_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (tail_raddr),
        .o_rdata (tail_q)
    );

    // Ring control state, bypass flags and the output register's valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_pos       <= '0;
            r_filled    <= '0;
            r_hbyp      <= 1'b0;
            r_tbyp      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_head   <= n_head;
            r_count  <= n_count;
            r_pos    <= n_pos;
            r_filled <= n_filled;
            r_hbyp   <= we && (waddr == head_raddr);
            r_tbyp   <= we && (waddr == tail_raddr);
            if (produce) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_wq <= wdata;
        if (produce) begin
            r_out_max  <= res_val;
            r_out_last <= i_item.last_sample;
        end
    end

    assign o_item_take   = take;
    assign o_valid       = r_out_valid;
    assign o_window_max  = r_out_max;
    assign o_last_window = r_out_last;

endmodule

// ----- sv/sliding_window_maximum.sv -----
// Sliding-window maximum filter: for each signed sample, once the window has filled within the
// current sequence, one item carries the largest of the last window_size samples, and the item
// of a sample marked last is flagged and restarts the sequence; a sequence shorter than the
// window gives no items. Samples enter a two-entry queue, so the input keeps flowing while the
// deque engine works. Before it takes a sample, the engine drops each candidate that leaves
// either end of its ring, one step per cycle; every sample is dropped at most once. The
// candidate ring is held in two copies of a RAM so that head and tail are read in the same
// cycle. No clearing pass follows reset. The user must write the window register through the
// configuration channel only while the block is idle; the block itself does not enforce this.
module sliding_window_maximum #(
    parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_last_sample,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [swm_pkg::SAMPLE_W-1:0] o_window_max,
    output logic                                o_last_window,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [swm_pkg::WIN_W-1:0]           i_cfg_data
);

    logic [swm_pkg::WIN_W-1:0] r_window;
    logic                      item_valid;
    swm_pkg::t_item            item;
    logic                      item_take;

    // Window size register; writes are always taken.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= swm_pkg::WIN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_window <= i_cfg_data;
        end
    end

    // Input queue.
    swm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample      (i_sample),
        .i_last_sample (i_last_sample),
        .o_item_valid  (item_valid),
        .o_item        (item),
        .i_item_take   (item_take)
    );

    // Deque engine and output register.
    swm_back #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_window      (r_window),
        .i_item_valid  (item_valid),
        .i_item        (item),
        .o_item_take   (item_take),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_window_max  (o_window_max),
        .o_last_window (o_last_window)
    );

    // The engine only takes a sample that the queue actually holds.
    a_take_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        item_take |-> item_valid)
        else $error("deque engine took an item from an empty queue");

    // A new result only appears right after the engine finished a sample.
    a_result_follows_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(item_take))
        else $error("result appeared without a completed sample");

    // A stalled result is never replaced by a new one.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> !$past(item_take) || $stable(o_window_max))
        else $error("waiting result was overwritten");

endmodule
